// ----- src/bmp_lsb_pkg.sv -----
// ----------------------------------------------------------------------------
// bmp_lsb_pkg
// shared types and constants for the bitmap lsb message embedder
// ----------------------------------------------------------------------------
`default_nettype none

package bmp_lsb_pkg;

  localparam int unsigned DefMessageDepth = 256;
  localparam int unsigned DefHeaderBytes  = 54;

  typedef enum logic [1:0] {
    ACT_START  = 2'd0,
    ACT_APPEND = 2'd1,
    ACT_IMAGE  = 2'd2
  } action_e;

  typedef struct packed {
    logic [1:0] action;
    logic [7:0] message_byte;
    logic [7:0] image_byte;
  } in_beat_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       is_last;
  } out_beat_t;

endpackage

`default_nettype wire

// ----- src/bmp_lsb_message_embedder_core.sv -----
// ----------------------------------------------------------------------------
// bmp_lsb_message_embedder_core
// hides a message in the least significant bits of a 32-bit bitmap stream
// ----------------------------------------------------------------------------
// One input beat is taken per clock cycle, back to back, while the skid entry
// is empty; an image beat that yields a result goes to the output register,
// or to the skid entry if the output stalls. The message bytes live in a
// single-port-write, registered-read buffer; the byte under the read pointer
// is always fetched ahead, a write of the same entry forwarded, so embedding
// never waits on the buffer. A two-entry output stage lets input continue for
// one beat while the consumer stalls. No clearing pass is needed after reset.
`default_nettype none

module bmp_lsb_message_embedder_core
  import bmp_lsb_pkg::*;
#(
  parameter int unsigned MessageDepth = DefMessageDepth,
  parameter int unsigned HeaderBytes  = DefHeaderBytes
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_ready_o,
  input  wire in_beat_t  in_data_i,
  output logic           out_valid_o,
  input  wire logic      out_ready_i,
  output out_beat_t      out_data_o
);

  localparam int unsigned AddrW = (MessageDepth > 1) ? $clog2(MessageDepth) : 1;
  localparam int unsigned CntW  = $clog2(MessageDepth + 1);
  localparam int unsigned IdxW  = (CntW > AddrW) ? CntW : AddrW + 1;

  localparam logic [1:0] PH_MSG  = 2'd0;
  localparam logic [1:0] PH_TERM = 2'd1;
  localparam logic [1:0] PH_COPY = 2'd2;

  logic [7:0]      mem_q [MessageDepth];
  logic [7:0]      rd_data_q;
  logic            fwd_q;
  logic [7:0]      fwd_data_q;

  logic [IdxW-1:0] count_q, count_d;
  logic [IdxW-1:0] rd_idx_q, rd_idx_d;
  logic [2:0]      bit_idx_q, bit_idx_d;
  logic [31:0]     pos_q, pos_d;
  logic [31:0]     fsize_q, fsize_d;
  logic [1:0]      pix_q, pix_d;
  logic [1:0]      phase_q, phase_d;

  logic            in_fire;
  logic            has_res;
  out_beat_t       res;
  logic            wr_en;
  logic [AddrW-1:0] wr_addr;
  logic [AddrW-1:0] rd_addr;
  logic [7:0]      msg_byte;
  logic            last_flag;
  logic [2:0]      eff_bit;

  out_beat_t       out_q, skid_q;
  logic            out_valid_q, skid_valid_q;

  assign in_ready_o  = !skid_valid_q;
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign msg_byte  = fwd_q ? fwd_data_q : rd_data_q;
  assign last_flag = (fsize_q != 32'd0) && (pos_q == fsize_q - 32'd1);
  assign wr_addr   = count_q[AddrW-1:0];
  assign rd_addr   = rd_idx_d[AddrW-1:0];

  always_comb begin
    count_d   = count_q;
    rd_idx_d  = rd_idx_q;
    bit_idx_d = bit_idx_q;
    pos_d     = pos_q;
    fsize_d   = fsize_q;
    pix_d     = pix_q;
    phase_d   = phase_q;
    wr_en     = 1'b0;
    has_res   = 1'b0;
    res       = '0;
    eff_bit   = bit_idx_q;
    if (in_fire) begin
      case (in_data_i.action)
        ACT_START: begin
          count_d   = '0;
          rd_idx_d  = '0;
          bit_idx_d = '0;
          pos_d     = '0;
          fsize_d   = '0;
          pix_d     = '0;
          phase_d   = PH_MSG;
        end
        ACT_APPEND: begin
          if (count_q < IdxW'(MessageDepth)) begin
            wr_en   = 1'b1;
            count_d = count_q + IdxW'(1);
          end
        end
        ACT_IMAGE: begin
          if (pos_q != 32'hFFFF_FFFF) begin
            pos_d = pos_q + 32'd1;
          end
          if (pos_q < 32'(HeaderBytes)) begin
            // file size, little endian, bytes two to five
            if (pos_q[31:3] == 29'd0) begin
              case (pos_q[2:0])
                3'd2:    fsize_d[7:0]   = in_data_i.image_byte;
                3'd3:    fsize_d[15:8]  = in_data_i.image_byte;
                3'd4:    fsize_d[23:16] = in_data_i.image_byte;
                3'd5:    fsize_d[31:24] = in_data_i.image_byte;
                default: ;
              endcase
            end
            has_res      = 1'b1;
            res.out_byte = in_data_i.image_byte;
            res.is_last  = 1'b0;
          end else if (phase_q == PH_MSG || phase_q == PH_TERM) begin
            pix_d        = pix_q + 2'd1;
            has_res      = 1'b1;
            res.out_byte = in_data_i.image_byte;
            res.is_last  = last_flag;
            if (pix_d != 2'd0) begin
              if (phase_q == PH_MSG && rd_idx_q < count_q) begin
                res.out_byte = {in_data_i.image_byte[7:1], msg_byte[bit_idx_q]};
                bit_idx_d    = bit_idx_q + 3'd1;
                if (bit_idx_d == 3'd0) begin
                  rd_idx_d = rd_idx_q + IdxW'(1);
                end
              end else begin
                // terminator bits
                if (phase_q == PH_MSG) begin
                  eff_bit = 3'd0;
                end
                res.out_byte = {in_data_i.image_byte[7:1], 1'b0};
                bit_idx_d    = eff_bit + 3'd1;
                phase_d      = (bit_idx_d == 3'd0) ? PH_COPY : PH_TERM;
              end
            end
          end else begin
            if (pos_q < fsize_q) begin
              has_res      = 1'b1;
              res.out_byte = in_data_i.image_byte;
              res.is_last  = last_flag;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // message buffer with write forwarding into the prefetched byte
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= in_data_i.message_byte;
    end
    rd_data_q  <= mem_q[rd_addr];
    fwd_data_q <= in_data_i.message_byte;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_q     <= 1'b0;
      count_q   <= '0;
      rd_idx_q  <= '0;
      bit_idx_q <= '0;
      pos_q     <= '0;
      fsize_q   <= '0;
      pix_q     <= '0;
      phase_q   <= PH_MSG;
    end else begin
      fwd_q     <= wr_en && (wr_addr == rd_addr);
      count_q   <= count_d;
      rd_idx_q  <= rd_idx_d;
      bit_idx_q <= bit_idx_d;
      pos_q     <= pos_d;
      fsize_q   <= fsize_d;
      pix_q     <= pix_d;
      phase_q   <= phase_d;
    end
  end

  // two-entry output stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && out_ready_i) begin
        if (skid_valid_q) begin
          skid_valid_q <= 1'b0;
        end else begin
          out_valid_q <= has_res;
        end
      end else if (has_res) begin
        if (out_valid_q) begin
          skid_valid_q <= 1'b1;
        end else begin
          out_valid_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_valid_q && out_ready_i) begin
      if (skid_valid_q) begin
        out_q <= skid_q;
      end else if (has_res) begin
        out_q <= res;
      end
    end else if (has_res) begin
      if (out_valid_q) begin
        skid_q <= res;
      end else begin
        out_q <= res;
      end
    end
  end

endmodule

`default_nettype wire

// ----- verif/bmp_lsb_embed_checker.sv -----
// ----------------------------------------------------------------------------
// bmp_lsb_embed_checker
// watches both channels of the lsb message embedder, keeps its own model of
// the message buffer, header parsing and bit embedding, and compares every
// output beat in order against the predicted byte and last flag
// ----------------------------------------------------------------------------
`default_nettype none

module bmp_lsb_embed_checker
  import bmp_lsb_pkg::*;
#(
  parameter int unsigned MessageDepth = DefMessageDepth,
  parameter int unsigned HeaderBytes  = DefHeaderBytes
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  input  wire logic      in_ready_i,
  input  wire in_beat_t  in_data_i,
  input  wire logic      out_valid_i,
  input  wire logic      out_ready_i,
  input  wire out_beat_t out_data_i,
  output int unsigned    fail_count_o,
  output int unsigned    pending_o
);

  localparam int unsigned AddrW = (MessageDepth > 1) ? $clog2(MessageDepth) : 1;
  localparam int unsigned CntW  = $clog2(MessageDepth + 1);

  typedef enum logic [1:0] {
    PH_MESSAGE,
    PH_TERMINATOR,
    PH_COPY
  } embed_phase_e;

  logic [7:0]      msg_mem [MessageDepth];
  logic [CntW-1:0] msg_cnt;
  logic [CntW-1:0] rd_idx;
  logic [2:0]      bit_idx;
  logic [31:0]     byte_pos;
  logic [31:0]     file_size;
  logic [1:0]      pix_phase;
  embed_phase_e    phase;

  out_beat_t       expected_bytes [$];

  function automatic logic at_last_byte();
    return (file_size != 32'd0) && (byte_pos == file_size - 32'd1);
  endfunction

  task automatic clear_job();
    msg_cnt   = '0;
    rd_idx    = '0;
    bit_idx   = '0;
    byte_pos  = '0;
    file_size = '0;
    pix_phase = '0;
    phase     = PH_MESSAGE;
  endtask

  task automatic predict_beat(input in_beat_t b);
    out_beat_t r;
    logic      emit;
    int        sel;
    r    = '0;
    emit = 1'b0;
    case (action_e'(b.action))
      ACT_START: begin
        clear_job();
      end
      ACT_APPEND: begin
        if (msg_cnt < MessageDepth) begin
          msg_mem[msg_cnt[AddrW-1:0]] = b.message_byte;
          msg_cnt++;
        end
      end
      ACT_IMAGE: begin
        if (byte_pos < HeaderBytes) begin
          if (byte_pos >= 32'd2 && byte_pos <= 32'd5) begin
            sel = int'(byte_pos) - 2;
            file_size[sel*8 +: 8] = b.image_byte;
          end
          r.out_byte = b.image_byte;
          r.is_last  = 1'b0;
          emit       = 1'b1;
        end else if (phase == PH_MESSAGE || phase == PH_TERMINATOR) begin
          r.out_byte = b.image_byte;
          pix_phase++;
          // alpha bytes pass untouched
          if (pix_phase != 2'd0) begin
            if (phase == PH_MESSAGE && rd_idx >= msg_cnt) begin
              phase   = PH_TERMINATOR;
              bit_idx = '0;
            end
            if (phase == PH_MESSAGE) begin
              r.out_byte[0] = msg_mem[rd_idx[AddrW-1:0]][bit_idx];
              bit_idx++;
              if (bit_idx == 3'd0) rd_idx++;
            end else begin
              r.out_byte[0] = 1'b0;
              bit_idx++;
              if (bit_idx == 3'd0) phase = PH_COPY;
            end
          end
          r.is_last = at_last_byte();
          emit      = 1'b1;
        end else if (byte_pos < file_size) begin
          r.out_byte = b.image_byte;
          r.is_last  = at_last_byte();
          emit       = 1'b1;
        end
        if (byte_pos != 32'hFFFF_FFFF) byte_pos++;
      end
      default: ;
    endcase
    if (emit) expected_bytes.push_back(r);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    out_beat_t exp_beat;
    if (!rst_ni) begin
      clear_job();
      expected_bytes.delete();
      fail_count_o = 0;
      pending_o    = 0;
    end else begin
      if (in_valid_i && in_ready_i) predict_beat(in_data_i);
      if (out_valid_i && out_ready_i) begin
        if (expected_bytes.size() == 0) begin
          $display("%0t unexpected output beat: expected none actual %02h last %0b",
                   $time, out_data_i.out_byte, out_data_i.is_last);
          fail_count_o++;
        end else begin
          exp_beat = expected_bytes.pop_front();
          if (out_data_i.out_byte !== exp_beat.out_byte) begin
            $display("%0t out_byte mismatch: expected %02h actual %02h",
                     $time, exp_beat.out_byte, out_data_i.out_byte);
            fail_count_o++;
          end
          if (out_data_i.is_last !== exp_beat.is_last) begin
            $display("%0t is_last mismatch: expected %0b actual %0b",
                     $time, exp_beat.is_last, out_data_i.is_last);
            fail_count_o++;
          end
        end
      end
      pending_o = expected_bytes.size();
    end
  end

endmodule

`default_nettype wire

// ----- verif/bmp_lsb_message_embedder_core_tb.sv -----
// ----------------------------------------------------------------------------
// bmp_lsb_message_embedder_core_tb
// drives whole embedding jobs (start, message bytes, bitmap header, pixel
// bytes) with noise and broken jobs mixed in, random gaps on the input and
// random back-pressure on the output; the checker beside the block predicts
// and compares every output beat
// ----------------------------------------------------------------------------
`default_nettype none

module bmp_lsb_message_embedder_core_tb;
  import bmp_lsb_pkg::*;

  localparam int unsigned MessageDepth  = DefMessageDepth;
  localparam int unsigned HeaderBytes   = DefHeaderBytes;
  localparam int unsigned RandomBeats   = 1400;
  localparam int unsigned FullJobPixels = 96;
  localparam logic [1:0]  ActUnused     = 2'd3;

  logic        clk       = 1'b0;
  logic        rst_n     = 1'b0;
  logic        in_valid  = 1'b0;
  in_beat_t    in_data   = '0;
  logic        out_ready = 1'b0;
  logic        in_ready;
  logic        out_valid;
  out_beat_t   out_data;
  int unsigned fail_count;
  int unsigned pending;
  bit          idle_on   = 1'b1;
  int unsigned beats_sent = 0;
  int unsigned stall_left = 0;

  bmp_lsb_message_embedder_core #(
    .MessageDepth(MessageDepth),
    .HeaderBytes (HeaderBytes)
  ) dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data)
  );

  bmp_lsb_embed_checker #(
    .MessageDepth(MessageDepth),
    .HeaderBytes (HeaderBytes)
  ) checker_i (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_i  (in_ready),
    .in_data_i   (in_data),
    .out_valid_i (out_valid),
    .out_ready_i (out_ready),
    .out_data_i  (out_data),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // output back-pressure in random bursts while idle_on is set
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready  <= 1'b0;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end else if (idle_on && out_ready && $urandom_range(0, 3) == 0) begin
      out_ready  <= 1'b0;
      stall_left <= $urandom_range(0, 7);
    end else begin
      out_ready <= 1'b1;
    end
  end

  task automatic send_beat(input logic [1:0] act, input logic [7:0] mb, input logic [7:0] ib);
    in_beat_t    b;
    int unsigned gap;
    b.action       = act;
    b.message_byte = mb;
    b.image_byte   = ib;
    if (idle_on && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 8);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= b;
    @(negedge clk);
    while (!in_ready) @(negedge clk);
    @(posedge clk);
    if (act != ActUnused) beats_sent++;
  endtask

  // hold the input until every predicted beat has come out
  task automatic drain();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic run_job(input bit with_start, input int unsigned msg_len,
                         input logic [31:0] fsize, input int unsigned pix_beats,
                         input bit noisy);
    logic [7:0] ib;
    if (with_start) send_beat(ACT_START, 8'($urandom), 8'($urandom));
    for (int i = 0; i < msg_len; i++) send_beat(ACT_APPEND, 8'($urandom), 8'($urandom));
    for (int p = 0; p < HeaderBytes + pix_beats; p++) begin
      if (noisy && $urandom_range(0, 24) == 0) begin
        if ($urandom_range(0, 1) == 0) send_beat(ActUnused, 8'($urandom), 8'($urandom));
        else send_beat(ACT_APPEND, 8'($urandom), 8'($urandom));
      end
      if (p >= 2 && p <= 5) ib = fsize[(p-2)*8 +: 8];
      else ib = 8'($urandom);
      send_beat(ACT_IMAGE, 8'($urandom), ib);
    end
  endtask

  initial begin
    int unsigned rand_base;
    int unsigned job_no;
    int unsigned msg_len;
    int unsigned emb_bits;
    int unsigned need;
    int unsigned pix;
    logic [31:0] fsize;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: unused code, extremes, file size inside the header
    send_beat(ActUnused, 8'hFF, 8'hFF);
    send_beat(ACT_START, 8'hFF, 8'hFF);
    send_beat(ACT_APPEND, 8'hFF, 8'h00);
    send_beat(ACT_APPEND, 8'h00, 8'hFF);
    send_beat(ActUnused, 8'h00, 8'h00);
    for (int i = 0; i < 16; i++) begin
      if (i == 2) send_beat(ACT_IMAGE, 8'hFF, 8'h03);
      else if (i >= 3 && i <= 5) send_beat(ACT_IMAGE, 8'h00, 8'h00);
      else send_beat(ACT_IMAGE, i[0] ? 8'hFF : 8'h00, i[0] ? 8'h00 : 8'hFF);
    end
    send_beat(ACT_START, 8'h00, 8'h00);
    send_beat(ACT_IMAGE, 8'h00, 8'h00);
    drain();

    // full buffer, overflow bytes ignored, start of the message embedded
    pix = FullJobPixels;
    run_job(1'b1, MessageDepth + 4, HeaderBytes + pix - 3, pix, 1'b0);
    drain();

    rand_base = beats_sent;
    job_no    = 0;
    while (beats_sent < rand_base + RandomBeats) begin
      job_no++;
      if (beats_sent > rand_base + RandomBeats - 300) idle_on = 1'b0;
      else idle_on = (job_no % 5 != 3);

      case ($urandom_range(0, 9))
        0:       msg_len = 0;
        7, 8:    msg_len = $urandom_range(5, 12);
        9:       msg_len = $urandom_range(13, 30);
        default: msg_len = $urandom_range(1, 4);
      endcase
      emb_bits = 8 * (msg_len + 1);
      need     = emb_bits + (emb_bits - 1) / 3;
      if ($urandom_range(0, 5) == 0) pix = $urandom_range(0, need);
      else pix = need + $urandom_range(0, 40);

      case ($urandom_range(0, 7))
        0:       fsize = 32'd0;
        1:       fsize = $urandom_range(1, HeaderBytes);
        5:       fsize = 32'hFFFF_FFFF;
        6:       fsize = $urandom;
        7:       fsize = HeaderBytes + pix - $urandom_range(0, 1);
        default: fsize = HeaderBytes + $urandom_range(0, pix + 10);
      endcase

      if ($urandom_range(0, 3) == 0) drain();
      run_job($urandom_range(0, 11) != 0, msg_len, fsize, pix, $urandom_range(0, 3) == 0);
    end

    drain();
    repeat (10) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule

`default_nettype wire

// ----- filelist.f -----
src/bmp_lsb_pkg.sv
src/bmp_lsb_message_embedder_core.sv
verif/bmp_lsb_embed_checker.sv
verif/bmp_lsb_message_embedder_core_tb.sv
